FILE: sv/obiw_pkg.sv
// ----------------------------------------------------------------------------
// Overlap box index walker package
// Shared payload types, command codes and fixed field widths.
// ----------------------------------------------------------------------------
package obiw_pkg;

	localparam int WINDOW_BITS = 60;
	localparam int ORIGIN_BITS = 36;
	localparam int EXTENT_BITS = 24;
	localparam int INDEX_BITS  = 24;

	localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_EMIT  = 1'b1;

	typedef struct packed {
		logic                   cmd;
		logic [WINDOW_BITS-1:0] x_window;
		logic [WINDOW_BITS-1:0] y_window;
		logic [WINDOW_BITS-1:0] z_window;
		logic [ORIGIN_BITS-1:0] orbit_origin;
		logic [EXTENT_BITS-1:0] orbit_extent;
		logic [ORIGIN_BITS-1:0] proj_origin;
		logic [EXTENT_BITS-1:0] proj_extent;
	} item_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] orbit_index;
		logic [INDEX_BITS-1:0] proj_index;
		logic                  last_point;
	} result_t;

	// What the front needs to know about the queue and the back end.
	typedef struct packed {
		logic full;
		logic idle;
	} status_t;

endpackage

FILE: sv/obiw_front.sv
// ----------------------------------------------------------------------------
// Overlap box index walker front end
// Takes items, keeps the walk position and pushes a point per emit in a walk.
// ----------------------------------------------------------------------------
module obiw_front #(
	parameter int COORD_BITS = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  obiw_pkg::item_t          item,
	input  obiw_pkg::status_t        status,
	output logic                     push,
	output logic [3*COORD_BITS+3:0]  push_data,
	output logic                     load,
	output logic [15*COORD_BITS-1:0] load_data
);

	localparam int C    = COORD_BITS;
	localparam int WPAD = (5*C > obiw_pkg::WINDOW_BITS) ? 5*C : obiw_pkg::WINDOW_BITS;
	localparam int OPAD = (3*C > obiw_pkg::ORIGIN_BITS) ? 3*C : obiw_pkg::ORIGIN_BITS;
	localparam int EPAD = (2*C > obiw_pkg::EXTENT_BITS) ? 2*C : obiw_pkg::EXTENT_BITS;

	typedef struct packed {
		logic [2:0][C-1:0] coord;
		logic [2:0]        sel;
		logic              last;
	} point_t;

	typedef struct packed {
		logic [2:0][C-1:0] shift;
		logic [2:0][C-1:0] orb_org;
		logic [2:0][C-1:0] prj_org;
		logic [C-1:0]      orb_nz;
		logic [C-1:0]      prj_nz;
		logic [2*C-1:0]    orb_plane;
		logic [2*C-1:0]    prj_plane;
	} load_t;

	logic [WPAD-1:0] win_pad [3];
	logic [OPAD-1:0] orb_org_pad, prj_org_pad;
	logic [EPAD-1:0] orb_ext_pad, prj_ext_pad;

	logic [C-1:0] in_lo1 [3];
	logic [C-1:0] in_hi1 [3];
	logic [C-1:0] in_lo2 [3];
	logic [C-1:0] in_hi2 [3];
	logic [2:0]   in_ok1;
	logic [2:0]   in_ok;

	logic [C-1:0] lo1_q [3];
	logic [C-1:0] hi1_q [3];
	logic [C-1:0] lo2_q [3];
	logic [C-1:0] hi2_q [3];
	logic [C-1:0] cnt_q [3];
	logic [2:0]   sel_q;
	logic         active_q;

	logic [2:0]   can_inc, can_sw, step_ok, carry;
	logic [C-1:0] cnt_d [3];
	logic [2:0]   sel_d;
	logic         last;
	logic         accept, start, emit;

	point_t pt;
	load_t  ld;

	assign win_pad[0]  = WPAD'(item.x_window);
	assign win_pad[1]  = WPAD'(item.y_window);
	assign win_pad[2]  = WPAD'(item.z_window);
	assign orb_org_pad = OPAD'(item.orbit_origin);
	assign prj_org_pad = OPAD'(item.proj_origin);
	assign orb_ext_pad = EPAD'(item.orbit_extent);
	assign prj_ext_pad = EPAD'(item.proj_extent);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			in_lo1[a] = win_pad[a][0 +: C];
			in_hi1[a] = win_pad[a][C +: C];
			in_lo2[a] = win_pad[a][2*C +: C];
			in_hi2[a] = win_pad[a][3*C +: C];
			in_ok1[a] = in_lo1[a] <= in_hi1[a];
			in_ok[a]  = in_ok1[a] || (in_lo2[a] <= in_hi2[a]);
		end
	end

	// A start waits until no earlier point still needs the loaded geometry.
	assign item_stall = status.full || ((item.cmd == obiw_pkg::CMD_START) && !status.idle);
	assign accept     = item_valid && !item_stall;
	assign start      = accept && (item.cmd == obiw_pkg::CMD_START);
	assign emit       = accept && (item.cmd == obiw_pkg::CMD_EMIT);
	assign push       = emit && active_q;

	// The z axis steps first; an axis that has run out rewinds and carries upward.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			can_inc[a] = cnt_q[a] < (sel_q[a] ? hi2_q[a] : hi1_q[a]);
			can_sw[a]  = !sel_q[a] && (lo2_q[a] <= hi2_q[a]);
			step_ok[a] = can_inc[a] || can_sw[a];
		end
		carry[2] = 1'b1;
		carry[1] = carry[2] && !step_ok[2];
		carry[0] = carry[1] && !step_ok[1];
		last     = carry[0] && !step_ok[0];
		for (int a = 0; a < 3; a++) begin
			cnt_d[a] = cnt_q[a];
			sel_d[a] = sel_q[a];
			if (carry[a]) begin
				if (can_inc[a]) begin
					cnt_d[a] = cnt_q[a] + C'(1);
				end else if (can_sw[a]) begin
					sel_d[a] = 1'b1;
					cnt_d[a] = lo2_q[a];
				end else if (a > 0) begin
					sel_d[a] = !(lo1_q[a] <= hi1_q[a]);
					cnt_d[a] = (lo1_q[a] <= hi1_q[a]) ? lo1_q[a] : lo2_q[a];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				lo1_q[a] <= '0;
				hi1_q[a] <= '0;
				lo2_q[a] <= '0;
				hi2_q[a] <= '0;
				cnt_q[a] <= '0;
			end
			sel_q    <= '0;
			active_q <= 1'b0;
		end else if (start) begin
			for (int a = 0; a < 3; a++) begin
				lo1_q[a] <= in_lo1[a];
				hi1_q[a] <= in_hi1[a];
				lo2_q[a] <= in_lo2[a];
				hi2_q[a] <= in_hi2[a];
				cnt_q[a] <= in_ok1[a] ? in_lo1[a] : in_lo2[a];
				sel_q[a] <= !in_ok1[a];
			end
			active_q <= &in_ok;
		end else if (push) begin
			for (int a = 0; a < 3; a++) begin
				cnt_q[a] <= cnt_d[a];
			end
			sel_q <= sel_d;
			if (last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			pt.coord[a]  = cnt_q[a];
			ld.shift[a]   = win_pad[a][4*C +: C];
			ld.orb_org[a] = orb_org_pad[a*C +: C];
			ld.prj_org[a] = prj_org_pad[a*C +: C];
		end
		pt.sel       = sel_q;
		pt.last      = last;
		ld.orb_nz    = orb_ext_pad[C +: C];
		ld.prj_nz    = prj_ext_pad[C +: C];
		ld.orb_plane = (2*C)'(orb_ext_pad[0 +: C]) * (2*C)'(orb_ext_pad[C +: C]);
		ld.prj_plane = (2*C)'(prj_ext_pad[0 +: C]) * (2*C)'(prj_ext_pad[C +: C]);
	end

	assign push_data = pt;
	assign load      = start;
	assign load_data = ld;

endmodule

FILE: sv/obiw_fifo.sv
// ----------------------------------------------------------------------------
// Overlap box index walker point queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module obiw_fifo #(
	parameter int WIDTH = 40,
	parameter int DEPTH_LOG2 = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             empty
);

	localparam int DEPTH = 1 << DEPTH_LOG2;

	logic [WIDTH-1:0]      entry_q [DEPTH];
	logic [DEPTH_LOG2-1:0] wr_ptr_q, rd_ptr_q;
	logic [DEPTH_LOG2:0]   count_q;

	assign full  = count_q == (DEPTH_LOG2+1)'(DEPTH);
	assign empty = count_q == '0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + DEPTH_LOG2'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + DEPTH_LOG2'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (DEPTH_LOG2+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (DEPTH_LOG2+1)'(1);
			end
		end
	end

endmodule

FILE: sv/obiw_back.sv
// ----------------------------------------------------------------------------
// Overlap box index walker back end
// Offset, stride multiply and sum-with-saturation pipeline for both boxes.
// ----------------------------------------------------------------------------
module obiw_back #(
	parameter int COORD_BITS = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic [15*COORD_BITS-1:0] load_data,
	input  logic                     pt_valid,
	input  logic [3*COORD_BITS+3:0]  pt_data,
	output logic                     pop,
	output logic                     busy,
	output logic                     result_valid,
	input  logic                     result_stall,
	output obiw_pkg::result_t        result
);

	localparam int C   = COORD_BITS;
	localparam int DW  = C + 2;
	localparam int PW  = DW + 2*C + 1;
	localparam int SW0 = PW + 2;
	localparam int SW  = (SW0 > obiw_pkg::INDEX_BITS) ? SW0 : obiw_pkg::INDEX_BITS + 1;

	typedef struct packed {
		logic [2:0][C-1:0] coord;
		logic [2:0]        sel;
		logic              last;
	} point_t;

	typedef struct packed {
		logic [2:0][C-1:0] shift;
		logic [2:0][C-1:0] orb_org;
		logic [2:0][C-1:0] prj_org;
		logic [C-1:0]      orb_nz;
		logic [C-1:0]      prj_nz;
		logic [2*C-1:0]    orb_plane;
		logic [2*C-1:0]    prj_plane;
	} load_t;

	function automatic logic [obiw_pkg::INDEX_BITS-1:0] saturate(logic signed [SW-1:0] v);
		logic [obiw_pkg::INDEX_BITS-1:0] r;
		if (v[SW-1]) begin
			r = '0;
		end else if (v > $signed(SW'(obiw_pkg::INDEX_MAX))) begin
			r = obiw_pkg::INDEX_MAX;
		end else begin
			r = v[obiw_pkg::INDEX_BITS-1:0];
		end
		return r;
	endfunction

	load_t  geo_q;
	point_t pt;

	logic                 v_s1, v_s2, result_valid_q;
	logic                 rdy1, rdy2, rdy3;
	logic signed [DW-1:0] d_orb_s1 [3];
	logic signed [DW-1:0] d_prj_s1 [3];
	logic                 last_s1;
	logic signed [PW-1:0] tx_orb_s2, ty_orb_s2, tx_prj_s2, ty_prj_s2;
	logic signed [DW-1:0] tz_orb_s2, tz_prj_s2;
	logic                 last_s2;
	logic signed [SW-1:0] sum_orb, sum_prj;
	obiw_pkg::result_t    result_q;

	assign pt = pt_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geo_q <= '0;
		end else if (load) begin
			geo_q <= load_data;
		end
	end

	assign rdy3 = !result_valid_q || !result_stall;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign pop  = pt_valid && rdy1;
	assign busy = v_s1 || v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= pop;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				result_valid_q <= v_s2;
			end
		end
	end

	// Offsets from each box's corner; the projector side takes the shift for
	// every axis that sits in its second range.
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int a = 0; a < 3; a++) begin
				d_orb_s1[a] <= $signed({2'b00, pt.coord[a]}) - $signed({2'b00, geo_q.orb_org[a]});
				d_prj_s1[a] <= $signed({2'b00, pt.coord[a]}) - $signed({2'b00, geo_q.prj_org[a]})
					- (pt.sel[a] ? $signed({{2{geo_q.shift[a][C-1]}}, geo_q.shift[a]})
						: $signed(DW'(0)));
			end
			last_s1 <= pt.last;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			tx_orb_s2 <= PW'(d_orb_s1[0]) * PW'($signed({1'b0, geo_q.orb_plane}));
			ty_orb_s2 <= PW'(d_orb_s1[1]) * PW'($signed({1'b0, geo_q.orb_nz}));
			tz_orb_s2 <= d_orb_s1[2];
			tx_prj_s2 <= PW'(d_prj_s1[0]) * PW'($signed({1'b0, geo_q.prj_plane}));
			ty_prj_s2 <= PW'(d_prj_s1[1]) * PW'($signed({1'b0, geo_q.prj_nz}));
			tz_prj_s2 <= d_prj_s1[2];
			last_s2   <= last_s1;
		end
	end

	assign sum_orb = SW'(tx_orb_s2) + SW'(ty_orb_s2) + SW'(tz_orb_s2);
	assign sum_prj = SW'(tx_prj_s2) + SW'(ty_prj_s2) + SW'(tz_prj_s2);

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			result_q.orbit_index <= saturate(sum_orb);
			result_q.proj_index  <= saturate(sum_prj);
			result_q.last_point  <= last_s2;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: sv/overlap_box_index_walker.sv
// ----------------------------------------------------------------------------
// Overlap box index walker
// Walks the overlap of an orbital box and a projector box and gives the flat
// index pair of one grid point for every emit transfer during a walk.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+----------------------------------
//  item     | item_valid   | item_stall   | item   (obiw_pkg::item_t)
//  result   | result_valid | result_stall | result (obiw_pkg::result_t)
//
// One item is taken per cycle while item_stall is low; the emit stream runs at
// one point per cycle while the queue has room. A point passes the queue and
// then the offset, multiply and sum stages on its way to the result register.
// A start item is held until the points before it have passed the multipliers.
// The point queue holds 2**QUEUE_LOG2 entries; when it is full, items stall.
// Reset clears the walk, so emits before the first start give no result.
// ----------------------------------------------------------------------------
module overlap_box_index_walker #(
	parameter int COORD_BITS = 12,
	parameter int QUEUE_LOG2 = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  obiw_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output obiw_pkg::result_t result
);

	localparam int PT_W = 3*COORD_BITS + 4;
	localparam int LD_W = 15*COORD_BITS;

	logic              push, pop, load, fifo_full, fifo_empty, back_busy;
	logic [PT_W-1:0]   push_data, head;
	logic [LD_W-1:0]   load_data;
	obiw_pkg::status_t status;

	assign status.full = fifo_full;
	assign status.idle = fifo_empty && !back_busy;

	obiw_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.status     (status),
		.push       (push),
		.push_data  (push_data),
		.load       (load),
		.load_data  (load_data)
	);

	obiw_fifo #(
		.WIDTH      (PT_W),
		.DEPTH_LOG2 (QUEUE_LOG2)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (fifo_full),
		.empty     (fifo_empty)
	);

	obiw_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.load_data    (load_data),
		.pt_valid     (!fifo_empty),
		.pt_data      (head),
		.pop          (pop),
		.busy         (back_busy),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: sv/obiw_checker.sv
// ----------------------------------------------------------------------------
// Overlap box index walker checker
// Port-level properties of the walker, bound to the top level.
// ----------------------------------------------------------------------------
module obiw_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input obiw_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input obiw_pkg::result_t result
);

	// A stalled result holds until it is transferred.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or vanished");

	// A start is taken only when no point is queued or in the offset or multiply stage, so no new result follows it.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.cmd == obiw_pkg::CMD_START)
		|=> !result_valid || $past(result_valid && result_stall))
		else $error("result appeared right after a start transfer");

	// An emit only stalls when the queue is full, which needs a busy result side.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall && (item.cmd == obiw_pkg::CMD_EMIT) |-> result_valid)
		else $error("emit stalled with no result pending");

endmodule

bind overlap_box_index_walker obiw_checker u_obiw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
